// File: hdl/swm_pkg.sv
// ============================================================================
// Sliding window minimum package
// Shared types and constants for the sliding window minimum unit.
// ============================================================================
package swm_pkg;

   localparam int SWM_CSR_INDEX_WIDTH = 8;
   localparam int SWM_CSR_DATA_WIDTH  = 32;
   localparam int SWM_PERIOD_WIDTH    = 11;
   localparam int SWM_COUNT_WIDTH     = 32;

   localparam logic [SWM_CSR_INDEX_WIDTH-1:0] SWM_REG_WINDOW_PERIOD = 8'd0;
   localparam logic [SWM_CSR_INDEX_WIDTH-1:0] SWM_REG_FIRST_INDEX   = 8'd1;

   localparam logic [SWM_PERIOD_WIDTH-1:0] SWM_RESET_PERIOD      = 11'd30;
   localparam logic [SWM_COUNT_WIDTH-1:0]  SWM_RESET_FIRST_INDEX = 32'd0;
   localparam logic [SWM_COUNT_WIDTH-1:0]  SWM_COUNT_MAX         = 32'hFFFF_FFFF;
   localparam int                          SWM_MIN_PERIOD        = 2;

   typedef enum logic [0:0] {
      SWM_IDLE,
      SWM_WORK
   } swm_state_type;

   // Operation applied to every cell of the chain in the same cycle.
   typedef struct packed {
      logic shift;   // drop the head entry, every cell takes its right neighbor
      logic insert;  // drop entries not below the new sample, append it
      logic clear;   // empty the whole chain
   } swm_ctrl_type;

endpackage

// File: hdl/swm_cell.sv
// ============================================================================
// Sliding window minimum cell
// One deque slot: a sample and its position tag. Shifts toward the head,
// drops itself when not below a new sample, takes the new sample, or clears.
// ============================================================================
module swm_cell #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int POS_WIDTH    = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_pkg::swm_ctrl_type          ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
   input  logic [POS_WIDTH-1:0]           new_pos,
   input  logic                           prev_keep,
   input  logic                           right_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
   input  logic [POS_WIDTH-1:0]           right_pos,
   output logic                           valid,
   output logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic [POS_WIDTH-1:0]           pos,
   output logic                           keep
);
   import swm_pkg::*;

   logic                           valid_ff;
   logic                           valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic [POS_WIDTH-1:0]           pos_ff;
   logic [POS_WIDTH-1:0]           pos_in;

   // The deque rises from head to tail, so the kept cells form a prefix.
   assign keep = valid_ff && (sample_ff < new_sample);

   always_comb begin
      valid_in  = valid_ff;
      sample_in = sample_ff;
      pos_in    = pos_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in  = right_valid;
         sample_in = right_sample;
         pos_in    = right_pos;
      end else if (ctrl.insert) begin
         if (!keep && prev_keep) begin
            valid_in  = 1'b1;
            sample_in = new_sample;
            pos_in    = new_pos;
         end else begin
            valid_in = keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      pos_ff    <= pos_in;
   end

   assign valid  = valid_ff;
   assign sample = sample_ff;
   assign pos    = pos_ff;

endmodule

// File: hdl/swm_chain.sv
// ============================================================================
// Sliding window minimum chain
// Row of deque cells with the head at cell zero and the tail growing right.
// ============================================================================
module swm_chain #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int DEPTH        = 1024,
   parameter int POS_WIDTH    = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_pkg::swm_ctrl_type          ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
   input  logic [POS_WIDTH-1:0]           new_pos,
   output logic                           head_valid,
   output logic signed [SAMPLE_WIDTH-1:0] head_sample,
   output logic [POS_WIDTH-1:0]           head_pos,
   output logic                           head_keep
);
   import swm_pkg::*;

   logic                           cell_valid  [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] cell_sample [DEPTH];
   logic [POS_WIDTH-1:0]           cell_pos    [DEPTH];
   logic                           cell_keep   [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                           prev_keep;
      logic                           right_valid;
      logic signed [SAMPLE_WIDTH-1:0] right_sample;
      logic [POS_WIDTH-1:0]           right_pos;

      if (i == 0) begin : g_first
         assign prev_keep = 1'b1;
      end else begin : g_inner
         assign prev_keep = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_valid  = 1'b0;
         assign right_sample = '0;
         assign right_pos    = '0;
      end else begin : g_next
         assign right_valid  = cell_valid[i+1];
         assign right_sample = cell_sample[i+1];
         assign right_pos    = cell_pos[i+1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .POS_WIDTH    (POS_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_sample   (new_sample),
         .new_pos      (new_pos),
         .prev_keep    (prev_keep),
         .right_valid  (right_valid),
         .right_sample (right_sample),
         .right_pos    (right_pos),
         .valid        (cell_valid[i]),
         .sample       (cell_sample[i]),
         .pos          (cell_pos[i]),
         .keep         (cell_keep[i])
      );
   end

   assign head_valid  = cell_valid[0];
   assign head_sample = cell_sample[0];
   assign head_pos    = cell_pos[0];
   assign head_keep   = cell_keep[0];

endmodule

// File: hdl/sliding_window_minimum_unit.sv
// ============================================================================
// Sliding window minimum unit
// Running minimum over the last window_period samples of a series.
// ============================================================================
// Samples enter on the req_ channel, one transaction each, with
// req_end_of_series marking the last sample of a series. A sample whose index
// reaches both the clamped window_period-1 and first_index produces one rsp_ transaction
// carrying the window minimum, the sample index, the running result count and
// the last flag. The csr_ channel writes window_period (index 0) and
// first_index (index 1); csr_ready is always high.
// Each sample is accepted in the idle state; the work state then shifts out
// every head entry that has aged out, one at a time, before the update of the
// cell chain. With a steady window_period at most one entry ages out per
// sample; after window_period is shortened many entries can age out at once.
// The result is registered and appears in the cycle after the update.
// The next sample is accepted while a result still waits; when the receiver
// stalls, the following result holds the update cycle until the output
// register is free.
// Reset empties the chain, clears the counters and loads window_period = 30
// and first_index = 0. End of series clears the same series state.
// ============================================================================
module sliding_window_minimum_unit #(
   parameter int MAX_PERIOD   = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_sample,
   input  logic                                     req_end_of_series,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]           rsp_minimum,
   output logic [swm_pkg::SWM_COUNT_WIDTH-1:0]      rsp_sample_index,
   output logic [swm_pkg::SWM_COUNT_WIDTH-1:0]      rsp_result_count,
   output logic                                     rsp_is_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [swm_pkg::SWM_CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [swm_pkg::SWM_CSR_DATA_WIDTH-1:0]   csr_data
);
   import swm_pkg::*;

   localparam int POS_WIDTH = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int AGE_WIDTH = POS_WIDTH + 1;

   // Configuration registers.
   logic [SWM_PERIOD_WIDTH-1:0] window_period_ff;
   logic [SWM_COUNT_WIDTH-1:0]  first_index_ff;

   // Sequencer and series state.
   swm_state_type                  state_ff;
   swm_state_type                  state_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           last_ff;
   logic [POS_WIDTH-1:0]           position_ff;
   logic [POS_WIDTH-1:0]           position_in;
   logic [SWM_COUNT_WIDTH-1:0]     sample_count_ff;
   logic [SWM_COUNT_WIDTH-1:0]     sample_count_in;
   logic [SWM_COUNT_WIDTH-1:0]     emit_count_ff;
   logic [SWM_COUNT_WIDTH-1:0]     emit_count_in;

   // Output register.
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_load;
   logic signed [SAMPLE_WIDTH-1:0] rsp_minimum_ff;
   logic [SWM_COUNT_WIDTH-1:0]     rsp_sample_index_ff;
   logic [SWM_COUNT_WIDTH-1:0]     rsp_result_count_ff;
   logic                           rsp_is_last_ff;

   swm_ctrl_type                   ctrl;
   logic                           head_valid;
   logic signed [SAMPLE_WIDTH-1:0] head_sample;
   logic [POS_WIDTH-1:0]           head_pos;
   logic                           head_keep;

   logic [31:0]                    period_wide;
   logic [AGE_WIDTH-1:0]           period;
   logic [AGE_WIDTH-1:0]           age_raw;
   logic [AGE_WIDTH-1:0]           age;
   logic                           expire;
   logic                           emit;
   logic [SWM_COUNT_WIDTH-1:0]     emit_next;
   logic signed [SAMPLE_WIDTH-1:0] window_min;
   logic                           req_accept;

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == SWM_IDLE);
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_period_ff <= SWM_RESET_PERIOD;
         first_index_ff   <= SWM_RESET_FIRST_INDEX;
      end else if (csr_valid) begin
         case (csr_index)
            SWM_REG_WINDOW_PERIOD: window_period_ff <= csr_data[SWM_PERIOD_WIDTH-1:0];
            SWM_REG_FIRST_INDEX:   first_index_ff   <= csr_data[SWM_COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Effective window length, held within 2 .. MAX_PERIOD.
   always_comb begin
      period_wide = 32'(window_period_ff);
      if (period_wide < 32'(SWM_MIN_PERIOD)) begin
         period_wide = 32'(SWM_MIN_PERIOD);
      end else if (period_wide > 32'(MAX_PERIOD)) begin
         period_wide = 32'(MAX_PERIOD);
      end
   end
   assign period = period_wide[AGE_WIDTH-1:0];

   // Age of the head entry; a full lap of the position counter reads as MAX_PERIOD.
   always_comb begin
      if (position_ff >= head_pos) begin
         age_raw = {1'b0, position_ff} - {1'b0, head_pos};
      end else begin
         age_raw = {1'b0, position_ff} + AGE_WIDTH'(MAX_PERIOD) - {1'b0, head_pos};
      end
      age = (age_raw == '0) ? AGE_WIDTH'(MAX_PERIOD) : age_raw;
   end

   assign expire     = head_valid && (age >= period);
   assign emit       = (sample_count_ff >= (period_wide - 32'd1)) &&
                       (sample_count_ff >= first_index_ff);
   assign emit_next  = (emit_count_ff == SWM_COUNT_MAX) ? emit_count_ff
                                                       : emit_count_ff + 32'd1;
   assign window_min = head_keep ? head_sample : sample_ff;

   always_comb begin
      state_in        = state_ff;
      ctrl            = '0;
      rsp_load        = 1'b0;
      position_in     = position_ff;
      sample_count_in = sample_count_ff;
      emit_count_in   = emit_count_ff;
      case (state_ff)
         SWM_IDLE: begin
            if (req_accept) begin
               state_in = SWM_WORK;
            end
         end
         SWM_WORK: begin
            if (expire) begin
               ctrl.shift = 1'b1;
            end else if (!(emit && rsp_valid_ff && !rsp_ready)) begin
               ctrl.insert = 1'b1;
               ctrl.clear  = last_ff;
               rsp_load    = emit;
               state_in    = SWM_IDLE;
               if (last_ff) begin
                  position_in     = '0;
                  sample_count_in = '0;
                  emit_count_in   = '0;
               end else begin
                  position_in = (32'(position_ff) == 32'(MAX_PERIOD - 1)) ? '0
                                                                          : position_ff + 1'b1;
                  if (sample_count_ff != SWM_COUNT_MAX) begin
                     sample_count_in = sample_count_ff + 32'd1;
                  end
                  if (emit) begin
                     emit_count_in = emit_next;
                  end
               end
            end
         end
         default: begin
            state_in = SWM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SWM_IDLE;
         position_ff     <= '0;
         sample_count_ff <= '0;
         emit_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         position_ff     <= position_in;
         sample_count_ff <= sample_count_in;
         emit_count_ff   <= emit_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_sample;
         last_ff   <= req_end_of_series;
      end
      if (rsp_load) begin
         rsp_minimum_ff      <= window_min;
         rsp_sample_index_ff <= sample_count_ff;
         rsp_result_count_ff <= emit_next;
         rsp_is_last_ff      <= last_ff;
      end
   end

   swm_chain #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DEPTH        (MAX_PERIOD),
      .POS_WIDTH    (POS_WIDTH)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .new_sample  (sample_ff),
      .new_pos     (position_ff),
      .head_valid  (head_valid),
      .head_sample (head_sample),
      .head_pos    (head_pos),
      .head_keep   (head_keep)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_minimum      = rsp_minimum_ff;
   assign rsp_sample_index = rsp_sample_index_ff;
   assign rsp_result_count = rsp_result_count_ff;
   assign rsp_is_last      = rsp_is_last_ff;

endmodule

// File: hdl/swm_checker.sv
// ============================================================================
// Sliding window minimum checker
// Port-level properties of the sliding window minimum unit.
// ============================================================================
module swm_checker #(
   parameter int SAMPLE_WIDTH = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0]      rsp_minimum,
   input logic [swm_pkg::SWM_COUNT_WIDTH-1:0] rsp_result_count
);
   import swm_pkg::*;

   // A stalled result keeps its value until the receiver takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_minimum))
      else $error("stalled result changed");

   // Only one sample is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while another is in work");

   // Every result counts itself, so the count is never zero.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_count != '0)
      else $error("result count is zero");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind sliding_window_minimum_unit swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_minimum      (rsp_minimum),
   .rsp_result_count (rsp_result_count)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Sliding window minimum unit testbench
// Drives sample series into the unit and checks every window minimum result
// against a behavioral model of the monotonic deque. Covers the reset
// configuration, directed corner cases, clamped and extreme window periods,
// mid-series period changes and random series with random back pressure.
// ============================================================================
module testbench;
   import swm_pkg::*;

   localparam int WINDOW_DEPTH = 1024;
   localparam int DATA_WIDTH   = 32;
   localparam int RESET_CYCLES = 10;
   localparam int QUIET_CYCLES = 1100;
   localparam int IDLE_LIMIT   = 10000;
   localparam int LONG_STALL   = 400;
   localparam int RANDOM_ITEMS = 300;
   localparam int RAMP_ITEMS   = 250;
   localparam int MAX_REPORTS  = 100;
   localparam logic [SWM_CSR_INDEX_WIDTH-1:0] UNUSED_REG_INDEX = 8'hFF;

   typedef enum int {
      STYLE_WIDE,
      STYLE_REPEAT,
      STYLE_RISING,
      STYLE_FALLING,
      STYLE_EXTREME
   } sample_style_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample;
      logic                         end_of_series;
   } sample_item_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] minimum;
      logic [SWM_COUNT_WIDTH-1:0]   sample_index;
      logic [SWM_COUNT_WIDTH-1:0]   result_count;
      logic                         is_last;
   } window_result_type;

   logic                              clock             = 1'b0;
   logic                              reset             = 1'b1;
   logic                              req_valid         = 1'b0;
   logic                              req_ready;
   logic signed [DATA_WIDTH-1:0]      req_sample        = '0;
   logic                              req_end_of_series = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready         = 1'b0;
   logic signed [DATA_WIDTH-1:0]      rsp_minimum;
   logic [SWM_COUNT_WIDTH-1:0]        rsp_sample_index;
   logic [SWM_COUNT_WIDTH-1:0]        rsp_result_count;
   logic                              rsp_is_last;
   logic                              csr_valid         = 1'b0;
   logic                              csr_ready;
   logic [SWM_CSR_INDEX_WIDTH-1:0]    csr_index         = '0;
   logic [SWM_CSR_DATA_WIDTH-1:0]     csr_data          = '0;

   sample_item_type   pending_samples[$];
   window_result_type expected_minima[$];

   bit steady_flow    = 1'b0;
   bit req_fire       = 1'b0;
   int stall_requests = 0;
   int stall_served   = 0;
   int req_gap        = 0;
   int rsp_wait       = 0;
   int rsp_hold       = 0;
   int pushed_total   = 0;
   int accepted_total = 0;
   int error_count    = 0;
   int idle_cycles    = 0;

   // Window model state.
   logic signed [DATA_WIDTH-1:0] win_sample[WINDOW_DEPTH];
   int                           win_pos[WINDOW_DEPTH];
   int                           win_head;
   int                           win_tail;
   int                           win_fill;
   int                           slot_pos;
   logic [SWM_COUNT_WIDTH-1:0]   series_index;
   logic [SWM_COUNT_WIDTH-1:0]   series_results;
   logic [SWM_PERIOD_WIDTH-1:0]  cfg_period;
   logic [SWM_COUNT_WIDTH-1:0]   cfg_first;

   sliding_window_minimum_unit #(
      .MAX_PERIOD   (WINDOW_DEPTH),
      .SAMPLE_WIDTH (DATA_WIDTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_end_of_series (req_end_of_series),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_minimum       (rsp_minimum),
      .rsp_sample_index  (rsp_sample_index),
      .rsp_result_count  (rsp_result_count),
      .rsp_is_last       (rsp_is_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_series();
      win_head       = 0;
      win_tail       = 0;
      win_fill       = 0;
      slot_pos       = 0;
      series_index   = '0;
      series_results = '0;
   endfunction

   // Advances the window by one sample; returns 1 when a minimum is due.
   function automatic bit advance_window(input logic signed [DATA_WIDTH-1:0] value,
                                         input logic eos,
                                         output window_result_type res);
      int                         period;
      int                         age;
      int                         back;
      logic [SWM_COUNT_WIDTH-1:0] n;
      bit                         emit;
      period = (cfg_period < SWM_MIN_PERIOD) ? SWM_MIN_PERIOD :
               (cfg_period > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cfg_period);
      n    = series_index;
      emit = 1'b0;
      res  = '0;
      // An age of zero means the entry went all the way around the ring.
      while (win_fill > 0) begin
         age = (slot_pos + WINDOW_DEPTH - win_pos[win_head]) % WINDOW_DEPTH;
         if (age == 0) age = WINDOW_DEPTH;
         if (age < period) break;
         win_head = (win_head + 1) % WINDOW_DEPTH;
         win_fill--;
      end
      while (win_fill > 0) begin
         back = (win_tail + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
         if (win_sample[back] < value) break;
         win_tail = back;
         win_fill--;
      end
      win_sample[win_tail] = value;
      win_pos[win_tail]    = slot_pos;
      win_tail             = (win_tail + 1) % WINDOW_DEPTH;
      win_fill++;
      if (n >= period - 1 && n >= cfg_first) begin
         if (series_results != SWM_COUNT_MAX) series_results++;
         res.minimum      = win_sample[win_head];
         res.sample_index = n;
         res.result_count = series_results;
         res.is_last      = eos;
         emit             = 1'b1;
      end
      slot_pos = (slot_pos + 1) % WINDOW_DEPTH;
      if (series_index != SWM_COUNT_MAX) series_index++;
      if (eos) clear_series();
      return emit;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_sample(input sample_style_type style,
                                                                input int step,
                                                                input int base);
      case (style)
         STYLE_WIDE:    return $urandom();
         STYLE_REPEAT:  return int'($urandom_range(0, 6)) - 3;
         STYLE_RISING:  return base + step * 977;
         STYLE_FALLING: return base - step * 977;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_REPORTS)
         $display("mismatch at %0t: %s: got %08h, expected %08h", $time, what, got, want);
      error_count++;
   endtask

   // Sample driver: a new transaction is offered only after the previous one
   // was taken at the last rising edge.
   always @(negedge clock) begin : drive_samples
      sample_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_samples.size() > 0) begin
            item = pending_samples.pop_front();
            req_valid         <= 1'b1;
            req_sample        <= item.sample;
            req_end_of_series <= item.end_of_series;
            req_gap           <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         rsp_hold     <= LONG_STALL;
         rsp_ready    <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_wait <= draw_gap();
      end
   end

   always @(posedge clock) begin : check_results
      window_result_type fresh;
      window_result_type oldest;
      req_fire <= req_valid && req_ready && !reset;
      if (reset) begin
         clear_series();
         cfg_period = SWM_RESET_PERIOD;
         cfg_first  = SWM_RESET_FIRST_INDEX;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == SWM_REG_WINDOW_PERIOD)
               cfg_period = csr_data[SWM_PERIOD_WIDTH-1:0];
            else if (csr_index == SWM_REG_FIRST_INDEX)
               cfg_first = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_minima.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_minimum, '0);
            end else begin
               oldest = expected_minima.pop_front();
               if (rsp_minimum !== oldest.minimum)
                  report_mismatch("minimum", rsp_minimum, oldest.minimum);
               if (rsp_sample_index !== oldest.sample_index)
                  report_mismatch("sample_index", rsp_sample_index, oldest.sample_index);
               if (rsp_result_count !== oldest.result_count)
                  report_mismatch("result_count", rsp_result_count, oldest.result_count);
               if (rsp_is_last !== oldest.is_last)
                  report_mismatch("is_last", 32'(rsp_is_last), 32'(oldest.is_last));
            end
         end
         if (req_valid && req_ready) begin
            accepted_total <= accepted_total + 1;
            if (advance_window(req_sample, req_end_of_series, fresh))
               expected_minima.push_back(fresh);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_sample(input logic signed [DATA_WIDTH-1:0] value, input logic eos);
      sample_item_type item;
      item.sample        = value;
      item.end_of_series = eos;
      pending_samples.push_back(item);
      pushed_total++;
   endtask

   task automatic queue_series(input int length, input bit terminate,
                               input sample_style_type style);
      int base;
      base = int'($urandom_range(0, 2000000)) - 1000000;
      for (int i = 0; i < length; i++)
         queue_sample(pick_sample(style, i, base), terminate && (i == length - 1));
   endtask

   // Waits until every queued sample was taken and every result arrived.
   task automatic wait_idle(input int extra);
      @(negedge clock);
      while (accepted_total != pushed_total || expected_minima.size() != 0)
         @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_register(input logic [SWM_CSR_INDEX_WIDTH-1:0] index,
                                 input logic [SWM_CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int period, input logic [SWM_COUNT_WIDTH-1:0] first);
      wait_idle(QUIET_CYCLES);
      write_register(SWM_REG_WINDOW_PERIOD, period);
      write_register(SWM_REG_FIRST_INDEX, first);
   endtask

   initial begin : stimulus
      int                         period;
      int                         eff;
      int                         length;
      int                         kind;
      int                         nseries;
      int                         phase;
      int                         random_items;
      bit                         terminate;
      logic [SWM_COUNT_WIDTH-1:0] first;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: a 30 sample window from index 0.
      queue_series(40, 1'b1, STYLE_WIDE);

      configure(2, 0);
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(4, 1'b1);
      // A one sample series ends before any result is due.
      queue_sample(-7, 1'b1);

      // Periods below the minimum behave as a two sample window.
      configure(0, 0);
      queue_sample(10, 1'b0);
      queue_sample(-10, 1'b0);
      queue_sample(20, 1'b1);
      configure(1, 3);
      for (int i = 1; i <= 6; i++) queue_sample(i, i == 6);

      // Writes to an unmapped register must leave the configuration alone.
      wait_idle(QUIET_CYCLES);
      write_register(UNUSED_REG_INDEX, 32'h0000_0005);
      queue_sample(8, 1'b0);
      queue_sample(9, 1'b0);
      queue_sample(7, 1'b1);

      configure(WINDOW_DEPTH, 32'hFFFF_FFFF);
      queue_series(4, 1'b1, STYLE_EXTREME);

      // A clamped full length window with a rising ramp builds a deep deque,
      // then a short window mid-series forces almost every entry to age out.
      configure(2047, 0);
      queue_series(RAMP_ITEMS, 1'b0, STYLE_RISING);
      configure(2, 0);
      queue_series(6, 1'b1, STYLE_WIDE);

      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       period = 2;
            1:       period = 3;
            2, 3, 4: period = $urandom_range(4, 12);
            5, 6:    period = $urandom_range(13, 40);
            7:       period = $urandom_range(41, 100);
            8:       period = $urandom_range(0, 1);
            default: period = $urandom_range(2, 8);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: first = '0;
            6, 7, 8:          first = $urandom_range(0, 3 * 100);
            default:          first = $urandom();
         endcase
         if (phase == 0) begin
            period = 2;
            first  = '0;
         end
         eff = (period < SWM_MIN_PERIOD) ? SWM_MIN_PERIOD : period;
         configure(period, first);
         @(posedge clock);
         steady_flow <= (phase == 1);
         // The receiver holds off while samples keep coming.
         if (phase == 0) stall_requests <= stall_requests + 1;
         nseries = (phase == 2) ? 2 : $urandom_range(1, 3);
         for (int s = 0; s < nseries; s++) begin
            // The sender pauses until everything is back before going on.
            if (phase == 2 && s == 1) wait_idle(0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               length    = eff + $urandom_range(0, 2 * eff + 4);
               terminate = 1'b1;
            end else if (kind < 9) begin
               length    = $urandom_range(1, eff - 1);
               terminate = 1'b1;
            end else begin
               // Left open, so the next phase changes the period mid-series.
               length    = $urandom_range(1, 2 * eff);
               terminate = 1'b0;
            end
            if (phase == 0) begin
               length    = 80;
               terminate = 1'b1;
            end
            queue_series(length, terminate, sample_style_type'($urandom_range(0, 4)));
            random_items += length;
         end
         phase++;
      end

      wait_idle(QUIET_CYCLES);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
